>>> sv/priority_watermark_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef PRIORITY_WATERMARK_ALLOCATOR_ASSERT_SVH
`define PRIORITY_WATERMARK_ALLOCATOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define PWA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pwa_pkg.sv
// Package for the priority watermark allocator: widths, codes, reset values
// and the watermark level function. No dependencies.
package pwa_pkg;

  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned USED_W     = 40;
  localparam int unsigned CTR_W      = 32;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned SZ_W       = 33;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [RES_W-1:0]  RESERVE_RST = 32'd33554432;
  localparam logic [BLK_W-1:0]  BLOCK_RST   = 16'd256;
  localparam logic [USED_W-1:0] USED_MAX    = {USED_W{1'b1}};
  localparam logic [CTR_W-1:0]  CTR_MAX     = {CTR_W{1'b1}};
  localparam logic [SZ_W-1:0]   MIN_SIZE    = 33'd16;
  localparam logic [CNT_W-1:0]  NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    FREE_BLOCK   = 1'b0,
    FREE_RESERVE = 1'b1
  } free_kind_t;

  typedef enum logic [1:0] {
    PRIO_LOW      = 2'd0,
    PRIO_NORMAL   = 2'd1,
    PRIO_HIGH     = 2'd2,
    PRIO_CRITICAL = 2'd3
  } prio_t;

  typedef enum logic [1:0] {
    WM_NORMAL   = 2'd0,
    WM_WARN     = 2'd1,
    WM_HIGH     = 2'd2,
    WM_CRITICAL = 2'd3
  } wm_t;

  typedef enum logic [2:0] {
    ST_BLOCK_GRANT   = 3'd0,
    ST_RESERVE_GRANT = 3'd1,
    ST_EMERGENCY     = 3'd2,
    ST_REJECTED      = 3'd3,
    ST_BAD_SIZE      = 3'd4,
    ST_BLOCK_FREED   = 3'd5,
    ST_RESERVE_FREED = 3'd6,
    ST_FREE_IGNORED  = 3'd7
  } status_t;

  typedef enum logic {
    REG_RESERVE_BYTES = 1'b0,
    REG_BLOCK_BYTES   = 1'b1
  } reg_idx_t;

  // Exact level: used*10 >= size*9, used*4 >= size*3, used*2 >= size.
  function automatic wm_t wm_level(input logic [USED_W-1:0] used,
                                   input logic [RES_W-1:0]  size);
    logic [43:0] u10;
    logic [43:0] s9;
    logic [41:0] u4;
    logic [41:0] s3;
    logic [40:0] u2;
    logic [40:0] s1;
    wm_t         lvl;
    u10 = {1'b0, used, 3'b000} + {3'b000, used, 1'b0};
    s9  = {9'b0, size, 3'b000} + {12'b0, size};
    u4  = {used, 2'b00};
    s3  = {9'b0, size, 1'b0} + {10'b0, size};
    u2  = {used, 1'b0};
    s1  = {9'b0, size};
    if (size == '0)       lvl = WM_NORMAL;
    else if (u10 >= s9)   lvl = WM_CRITICAL;
    else if (u4 >= s3)    lvl = WM_HIGH;
    else if (u2 >= s1)    lvl = WM_WARN;
    else                  lvl = WM_NORMAL;
    return lvl;
  endfunction

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
    return (c == CTR_MAX) ? c : c + CTR_W'(1);
  endfunction

endpackage

>>> sv/priority_watermark_allocator.sv
// Priority watermark allocator: free-list block stack plus bump reserve.
// Depends on pwa_pkg and priority_watermark_allocator_assert.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_ready  | command, size, priority, free kind/idx
//   out_    | output    | out_valid/out_ready| status, index, offset, level, totals
//   cfg     | input     | APB psel/penable   | reserve_bytes (0x0), block_bytes (0x4)
//
// One item per clock sustained while no result is held; an item waits in the input register
// and its result is written into the result register when the input register advances.
// The stack top is served by a registered read of the stack memory, prefetched
// from the next fill count, so pops and pushes may follow each other every cycle.
// Synchronous reset: stack reads back index i at entry i by a low-water mark
// on the fill count, so no clearing pass is needed after reset.
// A held result stalls the input register and freezes the allocator state.
`include "priority_watermark_allocator_assert.svh"

module priority_watermark_allocator import pwa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [31:0]         in_request_bytes,
  input  logic [1:0]          in_priority_req,
  input  logic                in_free_kind,
  input  logic [IDX_W-1:0]    in_free_block,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [IDX_W-1:0]    out_block_index,
  output logic [31:0]         out_reserve_offset,
  output logic [1:0]          out_watermark,
  output logic [CNT_W-1:0]    out_blocks_free,
  output logic [USED_W-1:0]   out_used_bytes,
  output logic [USED_W-1:0]   out_peak_bytes,
  output logic [CTR_W-1:0]    out_alloc_total,
  output logic [CTR_W-1:0]    out_free_total,
  output logic [CTR_W-1:0]    out_reject_total,
  output logic [CTR_W-1:0]    out_emergency_total
);

  // configuration registers
  logic [RES_W-1:0] reserve_r;
  logic [BLK_W-1:0] block_r;

  // input register
  logic             s1_v_r;
  cmd_t             s1_cmd_r;
  logic [31:0]      s1_req_r;
  prio_t            s1_prio_r;
  free_kind_t       s1_kind_r;
  logic [IDX_W-1:0] s1_blk_r;

  // allocator state
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  min_r;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [CTR_W-1:0]  alloc_r, alloc_nxt;
  logic [CTR_W-1:0]  freed_r, freed_nxt;
  logic [CTR_W-1:0]  reject_r, reject_nxt;
  logic [CTR_W-1:0]  emerg_r, emerg_nxt;

  // stack memory and its prefetched top
  logic [IDX_W-1:0] stack_mem [NUM_BLOCKS];
  logic [IDX_W-1:0] mem_q_r;
  logic             byp_v_r;
  logic [IDX_W-1:0] byp_d_r;
  logic             push;
  logic             push_en;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] rd_sum;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] top;

  // result register
  logic             out_v_r;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;
  logic [31:0]      roff_r, roff_nxt;

  // datapath
  logic             advance;
  logic [SZ_W-1:0]  req_rnd;
  logic [SZ_W-1:0]  sz_al;
  logic [SZ_W-1:0]  sz;
  logic             blk_hit;
  wm_t              wm_cur;
  logic             adm_rej;
  logic [USED_W:0]  need_sum;
  logic             no_room;
  logic [USED_W-1:0] used_add;

  // Move the input register on whenever the result register is free or emptying.
  assign advance  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || advance;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserve_r <= RESERVE_RST;
      block_r   <= BLOCK_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_RESERVE_BYTES: reserve_r <= pwdata;
        REG_BLOCK_BYTES:   block_r   <= pwdata[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_RESERVE_BYTES: prdata = reserve_r;
      REG_BLOCK_BYTES:   prdata = {16'b0, block_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_req_r  <= in_request_bytes;
      s1_prio_r <= prio_t'(in_priority_req);
      s1_kind_r <= free_kind_t'(in_free_kind);
      s1_blk_r  <= in_free_block;
    end
  end

  // ---------------- stack top ----------------
  // Entries below the low-water mark were never written and read back as
  // their own index; a push is forwarded while the registered memory read lags.
  assign cnt_m1 = cnt_r - CNT_W'(1);
  always_comb begin
    if (cnt_r == min_r)  top = cnt_m1[IDX_W-1:0];
    else if (byp_v_r)    top = byp_d_r;
    else                 top = mem_q_r;
  end

  // ---------------- single-pass step ----------------
  always_comb begin
    req_rnd  = {1'b0, s1_req_r} + SZ_W'(7);
    sz_al    = {req_rnd[SZ_W-1:3], 3'b000};
    sz       = (sz_al < MIN_SIZE) ? MIN_SIZE : sz_al;
    blk_hit  = (sz == {17'b0, block_r}) && (cnt_r != '0);
    wm_cur   = wm_level(used_r, reserve_r);
    adm_rej  = ((s1_prio_r == PRIO_LOW) && (wm_cur == WM_HIGH || wm_cur == WM_CRITICAL))
            || ((s1_prio_r == PRIO_LOW || s1_prio_r == PRIO_NORMAL)
                && (wm_cur == WM_CRITICAL));
    need_sum = {1'b0, used_r} + {8'b0, sz};
    // Past the end of the reserve, or already beyond it.
    no_room  = need_sum > {9'b0, reserve_r};
    used_add = (need_sum > {1'b0, USED_MAX}) ? USED_MAX : need_sum[USED_W-1:0];
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    used_nxt   = used_r;
    alloc_nxt  = alloc_r;
    freed_nxt  = freed_r;
    reject_nxt = reject_r;
    emerg_nxt  = emerg_r;
    status_nxt = ST_BAD_SIZE;
    bidx_nxt   = '0;
    roff_nxt   = '0;
    push       = 1'b0;
    case (s1_cmd_r)
      CMD_ALLOC: begin
        if (s1_req_r == '0) begin
          status_nxt = ST_BAD_SIZE;
        end else if (blk_hit) begin
          cnt_nxt    = cnt_m1;
          bidx_nxt   = top;
          alloc_nxt  = sat_inc(alloc_r);
          status_nxt = ST_BLOCK_GRANT;
        end else if (adm_rej) begin
          reject_nxt = sat_inc(reject_r);
          status_nxt = ST_REJECTED;
        end else if (no_room) begin
          if (s1_prio_r == PRIO_CRITICAL) begin
            used_nxt   = used_add;
            emerg_nxt  = sat_inc(emerg_r);
            alloc_nxt  = sat_inc(alloc_r);
            status_nxt = ST_EMERGENCY;
          end else begin
            reject_nxt = sat_inc(reject_r);
            status_nxt = ST_REJECTED;
          end
        end else begin
          roff_nxt   = used_r[31:0];
          used_nxt   = used_add;
          alloc_nxt  = sat_inc(alloc_r);
          status_nxt = ST_RESERVE_GRANT;
        end
      end
      CMD_FREE: begin
        if (s1_kind_r == FREE_RESERVE) begin
          freed_nxt  = sat_inc(freed_r);
          status_nxt = ST_RESERVE_FREED;
        end else if (({1'b0, s1_blk_r} >= NUM_BLOCKS_C) || (cnt_r >= NUM_BLOCKS_C)) begin
          status_nxt = ST_FREE_IGNORED;
        end else begin
          push       = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          freed_nxt  = sat_inc(freed_r);
          status_nxt = ST_BLOCK_FREED;
        end
      end
      default: ;
    endcase
  end

  // ---------------- state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= NUM_BLOCKS_C;
      min_r    <= NUM_BLOCKS_C;
      used_r   <= '0;
      alloc_r  <= '0;
      freed_r  <= '0;
      reject_r <= '0;
      emerg_r  <= '0;
      byp_v_r  <= 1'b0;
    end else begin
      byp_v_r <= push_en;
      if (advance) begin
        cnt_r    <= cnt_nxt;
        used_r   <= used_nxt;
        alloc_r  <= alloc_nxt;
        freed_r  <= freed_nxt;
        reject_r <= reject_nxt;
        emerg_r  <= emerg_nxt;
        if (cnt_nxt < min_r) begin
          min_r <= cnt_nxt;
        end
      end
    end
  end

  // Prefetch the entry under the next fill count so the top is ready next cycle.
  assign push_en = advance && push;
  assign cnt_eff = advance ? cnt_nxt : cnt_r;
  assign rd_sum  = cnt_eff - CNT_W'(1);
  assign rd_addr = rd_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[cnt_r[IDX_W-1:0]] <= s1_blk_r;
    end
    mem_q_r <= stack_mem[rd_addr];
    byp_d_r <= s1_blk_r;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
      bidx_r   <= bidx_nxt;
      roff_r   <= roff_nxt;
    end
  end

  // State is frozen while a result waits, so it doubles as the result snapshot.
  // Usage never falls, so the peak is the usage itself.
  assign out_valid           = out_v_r;
  assign out_status          = status_r;
  assign out_block_index     = bidx_r;
  assign out_reserve_offset  = roff_r;
  assign out_watermark       = wm_cur;
  assign out_blocks_free     = cnt_r;
  assign out_used_bytes      = used_r;
  assign out_peak_bytes      = used_r;
  assign out_alloc_total     = alloc_r;
  assign out_free_total      = freed_r;
  assign out_reject_total    = reject_r;
  assign out_emergency_total = emerg_r;

  // ---------------- assertions ----------------
  `PWA_ASSERT(a_cnt_bound, (cnt_r <= NUM_BLOCKS_C) && (min_r <= cnt_r),
              "fill count outside low-water mark and stack depth")
  `PWA_ASSERT_NEXT(a_used_mono, 1'b1, used_r >= $past(used_r),
                   "reserve usage decreased")
  `PWA_ASSERT_NEXT(a_stall_freeze, out_v_r && !out_ready,
                   $stable(cnt_r) && $stable(used_r) && $stable(alloc_r),
                   "state moved while a result was held")
  `PWA_ASSERT_NEXT(a_pop_count, advance && (status_nxt == ST_BLOCK_GRANT),
                   cnt_r == $past(cnt_r) - CNT_W'(1),
                   "block grant did not pop exactly one entry")

endmodule

>>> sim/testbench.sv
// Self-checking bench for the priority watermark allocator: requests go in over a
// valid/ready driver, results are checked field by field against an in-bench model.
// Depends on pwa_pkg and the priority_watermark_allocator RTL.
module testbench;
  import pwa_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_CAP    = 10;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned LONG_STALL    = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [63:0] USED_CEIL     = 64'(USED_MAX);

  // One request as offered on the input channel.
  typedef struct packed {
    cmd_t             command;
    logic [31:0]      request_bytes;
    prio_t            urgency;
    free_kind_t       kind;
    logic [IDX_W-1:0] slot;
  } alloc_req_t;

  // One predicted result.
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [31:0]       reserve_offset;
    wm_t               level;
    logic [CNT_W-1:0]  blocks_free;
    logic [USED_W-1:0] used;
    logic [USED_W-1:0] peak;
    logic [CTR_W-1:0]  allocs;
    logic [CTR_W-1:0]  frees;
    logic [CTR_W-1:0]  rejects;
    logic [CTR_W-1:0]  emergencies;
  } alloc_resp_t;

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr           = '0;
  logic [31:0]       pwdata           = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic              in_command       = 1'b0;
  logic [31:0]       in_request_bytes = '0;
  logic [1:0]        in_priority_req  = '0;
  logic              in_free_kind     = 1'b0;
  logic [IDX_W-1:0]  in_free_block    = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [2:0]        out_status;
  logic [IDX_W-1:0]  out_block_index;
  logic [31:0]       out_reserve_offset;
  logic [1:0]        out_watermark;
  logic [CNT_W-1:0]  out_blocks_free;
  logic [USED_W-1:0] out_used_bytes;
  logic [USED_W-1:0] out_peak_bytes;
  logic [CTR_W-1:0]  out_alloc_total;
  logic [CTR_W-1:0]  out_free_total;
  logic [CTR_W-1:0]  out_reject_total;
  logic [CTR_W-1:0]  out_emergency_total;

  priority_watermark_allocator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_request_bytes    (in_request_bytes),
    .in_priority_req     (in_priority_req),
    .in_free_kind        (in_free_kind),
    .in_free_block       (in_free_block),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_block_index     (out_block_index),
    .out_reserve_offset  (out_reserve_offset),
    .out_watermark       (out_watermark),
    .out_blocks_free     (out_blocks_free),
    .out_used_bytes      (out_used_bytes),
    .out_peak_bytes      (out_peak_bytes),
    .out_alloc_total     (out_alloc_total),
    .out_free_total      (out_free_total),
    .out_reject_total    (out_reject_total),
    .out_emergency_total (out_emergency_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Allocator model: free stack, reserve usage, totals and the two registers.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] stack_mem [NUM_BLOCKS];
  int unsigned      stack_fill;
  logic [63:0]      used_q;
  logic [63:0]      peak_q;
  logic [CTR_W-1:0] grants_n;
  logic [CTR_W-1:0] frees_n;
  logic [CTR_W-1:0] rejects_n;
  logic [CTR_W-1:0] emergencies_n;
  logic [31:0]      model_reserve;
  logic [15:0]      model_block;

  // Queues between the stimulus, the driver and the monitor.
  alloc_req_t  request_backlog[$];
  alloc_resp_t awaited[$];
  alloc_req_t  offer;

  // Bench controls and tallies.
  bit          quiet         = 1'b0;
  bit          stall_request = 1'b0;
  bit          stall_begun   = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned requests_n    = 0;
  int unsigned replies_n     = 0;
  int unsigned settings_n    = 0;
  int unsigned status_tally [8];

  function automatic void reset_books();
    for (int i = 0; i < NUM_BLOCKS; i++) stack_mem[i] = IDX_W'(i);
    stack_fill    = NUM_BLOCKS;
    used_q        = '0;
    peak_q        = '0;
    grants_n      = '0;
    frees_n       = '0;
    rejects_n     = '0;
    emergencies_n = '0;
    model_reserve = RESERVE_RST;
    model_block   = BLOCK_RST;
  endfunction

  // Saturating tally: hold at all-ones.
  function automatic logic [CTR_W-1:0] count_up(input logic [CTR_W-1:0] c);
    return c + CTR_W'(c != CTR_MAX);
  endfunction

  function automatic void charge_reserve(input logic [63:0] amount);
    if (amount >= USED_CEIL - used_q) used_q = USED_CEIL;
    else used_q = used_q + amount;
    if (used_q > peak_q) peak_q = used_q;
  endfunction

  // Usage level against the reserve, with no rounding anywhere.
  function automatic wm_t usage_level(input logic [63:0] used, input logic [31:0] size);
    logic [63:0] cap;
    cap = 64'(size);
    if (cap == 0) return WM_NORMAL;
    if (used * 10 >= cap * 9) return WM_CRITICAL;
    if (used * 4 >= cap * 3) return WM_HIGH;
    if (used * 2 >= cap) return WM_WARN;
    return WM_NORMAL;
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic alloc_resp_t serve_request(input alloc_req_t r);
    alloc_resp_t res;
    logic [63:0] rounded;
    logic [63:0] room;
    wm_t         lvl;
    res.status         = ST_BAD_SIZE;
    res.block_index    = '0;
    res.reserve_offset = '0;
    if (r.command == CMD_ALLOC) begin
      if (r.request_bytes != '0) begin
        rounded = (64'(r.request_bytes) + 64'd7) & ~64'd7;
        if (rounded < 64'd16) rounded = 64'd16;
        if (rounded == 64'(model_block) && stack_fill != 0) begin
          // pop the top of the free stack, no admission check
          stack_fill      = stack_fill - 1;
          res.block_index = stack_mem[stack_fill];
          grants_n        = count_up(grants_n);
          res.status      = ST_BLOCK_GRANT;
        end else begin
          lvl  = usage_level(used_q, model_reserve);
          room = (used_q >= 64'(model_reserve)) ? 64'd0 : 64'(model_reserve) - used_q;
          if ((r.urgency == PRIO_LOW && lvl >= WM_HIGH) ||
              (r.urgency <= PRIO_NORMAL && lvl == WM_CRITICAL)) begin
            rejects_n  = count_up(rejects_n);
            res.status = ST_REJECTED;
          end else if (rounded > room && r.urgency == PRIO_CRITICAL) begin
            // critical overflow: grant anyway and still charge the usage
            charge_reserve(rounded);
            emergencies_n = count_up(emergencies_n);
            grants_n      = count_up(grants_n);
            res.status    = ST_EMERGENCY;
          end else if (rounded > room) begin
            rejects_n  = count_up(rejects_n);
            res.status = ST_REJECTED;
          end else begin
            res.reserve_offset = used_q[31:0];
            charge_reserve(rounded);
            grants_n   = count_up(grants_n);
            res.status = ST_RESERVE_GRANT;
          end
        end
      end
    end else if (r.kind == FREE_RESERVE) begin
      frees_n    = count_up(frees_n);
      res.status = ST_RESERVE_FREED;
    end else if (32'(r.slot) >= NUM_BLOCKS || stack_fill >= NUM_BLOCKS) begin
      res.status = ST_FREE_IGNORED;
    end else begin
      stack_mem[stack_fill] = r.slot;
      stack_fill            = stack_fill + 1;
      frees_n               = count_up(frees_n);
      res.status            = ST_BLOCK_FREED;
    end
    res.level       = usage_level(used_q, model_reserve);
    res.blocks_free = CNT_W'(stack_fill);
    res.used        = used_q[USED_W-1:0];
    res.peak        = peak_q[USED_W-1:0];
    res.allocs      = grants_n;
    res.frees       = frees_n;
    res.rejects     = rejects_n;
    res.emergencies = emergencies_n;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields a request does not use still get random values.
  // ---------------------------------------------------------------------------
  function automatic void queue_alloc(input logic [31:0] bytes, input prio_t urgency);
    alloc_req_t r;
    r.command       = CMD_ALLOC;
    r.request_bytes = bytes;
    r.urgency       = urgency;
    r.kind          = free_kind_t'($urandom_range(1));
    r.slot          = IDX_W'($urandom);
    request_backlog.push_back(r);
  endfunction

  function automatic void queue_free(input free_kind_t kind, input logic [IDX_W-1:0] slot);
    alloc_req_t r;
    r.command       = CMD_FREE;
    r.request_bytes = $urandom;
    r.urgency       = prio_t'($urandom_range(3));
    r.kind          = kind;
    r.slot          = slot;
    request_backlog.push_back(r);
  endfunction

  // A size that rounds to the block size if that is a multiple of eight, or to the minimum for blocks under it.
  function automatic logic [31:0] block_sized();
    if (model_block >= 16'd16) return $urandom_range(32'(model_block), 32'(model_block) - 7);
    return $urandom_range(16, 1);
  endfunction

  // Reserve sized to sit well above the current usage, so every level is crossed.
  function automatic logic [31:0] fresh_reserve();
    return 32'(used_q * 2 + 64'd2000 + 64'($urandom_range(4000)));
  endfunction

  // Random mix of every request kind; huge critical requests only where asked.
  function automatic void queue_mix(input int unsigned n, input bit huge_critical);
    int unsigned span;
    int unsigned pick;
    prio_t       any_prio;
    span = (model_reserve > 32'd1200000) ? 100000 : model_reserve / 12 + 16;
    repeat (n) begin
      pick     = $urandom_range(99);
      any_prio = prio_t'($urandom_range(3));
      if (pick < 28) queue_alloc($urandom_range(span, 1), any_prio);
      else if (pick < 56) queue_alloc(block_sized(), any_prio);
      else if (pick < 68) queue_free(FREE_BLOCK, IDX_W'($urandom));
      else if (pick < 76) queue_free(FREE_RESERVE, IDX_W'($urandom));
      else if (pick < 81) queue_alloc('0, any_prio);
      else if (pick < 91)
        queue_alloc($urandom | 32'h8000_0000,
                    huge_critical ? any_prio : prio_t'($urandom_range(2)));
      else queue_alloc($urandom_range(span, 1), PRIO_CRITICAL);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes: setup cycle, access cycle, register written on the
  // edge that closes the access. Only called with the block idle.
  // ---------------------------------------------------------------------------
  task automatic write_register(input reg_idx_t which, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(which));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_RESERVE_BYTES) model_reserve = value;
    else model_block = value[15:0];
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] reserve, input logic [15:0] blk);
    write_register(REG_RESERVE_BYTES, reserve);
    write_register(REG_BLOCK_BYTES, 32'(blk));
    settings_n++;
  endtask

  // Hold the sender until every request is in and every result is back.
  task automatic drain_and_settle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || awaited.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predict on acceptance, then offer the next item or idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited.push_back(serve_request(offer));
        requests_n++;
      end
      // load only when nothing is held, so valid never drops before acceptance
      if (!in_valid || in_ready) begin
        if (request_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          offer            = request_backlog.pop_front();
          in_valid         <= 1'b1;
          in_command       <= offer.command;
          in_request_bytes <= offer.request_bytes;
          in_priority_req  <= offer.urgency;
          in_free_kind     <= offer.kind;
          in_free_block    <= offer.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic note_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("result %0d, %s: expected %0h, got %0h", replies_n, what, want, got);
    end
  endtask

  task automatic compare_reply(input alloc_resp_t want);
    note_field("status", 64'(want.status), 64'(out_status));
    note_field("block_index", 64'(want.block_index), 64'(out_block_index));
    note_field("reserve_offset", 64'(want.reserve_offset), 64'(out_reserve_offset));
    note_field("watermark", 64'(want.level), 64'(out_watermark));
    note_field("blocks_free", 64'(want.blocks_free), 64'(out_blocks_free));
    note_field("used_bytes", 64'(want.used), 64'(out_used_bytes));
    note_field("peak_bytes", 64'(want.peak), 64'(out_peak_bytes));
    note_field("alloc_total", 64'(want.allocs), 64'(out_alloc_total));
    note_field("free_total", 64'(want.frees), 64'(out_free_total));
    note_field("reject_total", 64'(want.rejects), 64'(out_reject_total));
    note_field("emergency_total", 64'(want.emergencies), 64'(out_emergency_total));
    status_tally[want.status]++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("result with nothing outstanding, status %0h", out_status);
        end else begin
          compare_reply(awaited.pop_front());
        end
        replies_n++;
      end
      // one long hold-off on request, else random back-pressure
      if (stall_request && !stall_begun) begin
        stall_begun <= 1'b1;
        stall_left  <= LONG_STALL;
        out_ready   <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_books();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings (32 MiB reserve, 256-byte blocks).
    queue_alloc(32'd0, PRIO_LOW);               // bad size
    queue_alloc(32'd1, PRIO_LOW);               // rounds up to the minimum
    queue_alloc(32'd8, PRIO_NORMAL);            // still the minimum
    queue_alloc(32'd9, PRIO_HIGH);
    queue_alloc(32'd17, PRIO_CRITICAL);         // rounds to 24
    queue_alloc(32'd256, PRIO_NORMAL);          // block grant, top of stack
    queue_alloc(32'd249, PRIO_LOW);             // rounds onto the block size
    queue_alloc(32'd248, PRIO_HIGH);            // just under: reserve
    queue_alloc(32'd257, PRIO_CRITICAL);        // just over: reserve
    queue_alloc(32'hFFFF_FFFF, PRIO_LOW);       // no room
    queue_alloc(32'hFFFF_FFFF, PRIO_HIGH);      // no room
    queue_alloc(32'h0200_0000, PRIO_NORMAL);    // whole reserve, partly used
    queue_free(FREE_BLOCK, IDX_W'(1023));
    queue_free(FREE_BLOCK, IDX_W'(0));          // stack back to full
    queue_free(FREE_BLOCK, IDX_W'(512));        // full stack: ignored
    queue_free(FREE_RESERVE, IDX_W'(0));        // counted only
    queue_alloc(32'd256, PRIO_LOW);             // pops the last index pushed
    queue_free(FREE_RESERVE, IDX_W'(1023));
    queue_alloc(32'd0, PRIO_CRITICAL);          // bad size regardless of priority
    queue_free(FREE_BLOCK, IDX_W'(1023));
    queue_alloc(32'd256, PRIO_HIGH);
    drain_and_settle();

    // Smallest block size, with no idling on either side.
    quiet = 1'b1;
    reconfigure(fresh_reserve(), 16'd16);
    queue_mix(40, 1'b0);
    drain_and_settle();
    quiet = 1'b0;

    // Largest block size.
    reconfigure(fresh_reserve(), 16'd65528);
    queue_mix(30, 1'b0);
    drain_and_settle();

    // Block size that is not a multiple of eight: never matches.
    reconfigure(fresh_reserve(), 16'd100);
    queue_mix(20, 1'b0);
    drain_and_settle();

    // Smallest nonzero reserve and a block size under the minimum.
    reconfigure(32'd1, 16'd8);
    queue_mix(15, 1'b0);
    drain_and_settle();

    // Zero reserve: level stays normal, only block-sized or critical requests get through.
    reconfigure(32'd0, BLOCK_RST);
    queue_mix(15, 1'b0);
    drain_and_settle();

    // Empty the free stack under a long receiver hold-off, then run past empty.
    reconfigure(fresh_reserve(), 16'd24);
    stall_request = 1'b1;
    repeat (stack_fill + 12) begin
      queue_alloc(block_sized(), prio_t'($urandom_range(3)));
      if ($urandom_range(19) == 0) queue_free(FREE_RESERVE, IDX_W'($urandom));
    end
    drain_and_settle();

    // Work around an empty or nearly empty stack.
    reconfigure(fresh_reserve(), 16'd24);
    queue_mix(30, 1'b0);
    drain_and_settle();

    // Largest reserve: large grants, then critical overflow until usage saturates.
    reconfigure(32'hFFFF_FFFF, BLOCK_RST);
    for (int i = 0; i < 270; i++) begin
      queue_alloc(32'hFFFF_FFFF - $urandom_range(6), PRIO_CRITICAL);
      if (i % 10 == 0) queue_mix(1, 1'b1);
    end
    drain_and_settle();

    // Catch any stray result after the last one expected.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (awaited.size() != 0) begin
      $display("%0d results never arrived", awaited.size());
      mismatches++;
    end

    $display("covered %0d requests over %0d settings: %0d block, %0d reserve, %0d emergency grants",
             requests_n, settings_n, status_tally[ST_BLOCK_GRANT],
             status_tally[ST_RESERVE_GRANT], status_tally[ST_EMERGENCY]);
    $display("  %0d rejected, %0d bad size, frees %0d block / %0d reserve / %0d ignored",
             status_tally[ST_REJECTED], status_tally[ST_BAD_SIZE],
             status_tally[ST_BLOCK_FREED], status_tally[ST_RESERVE_FREED],
             status_tally[ST_FREE_IGNORED]);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
